@@ rtl/core/jet_pkg.sv @@
package jet_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 28;
    localparam int REG_W      = 31;
    localparam int CNT_W      = 7;
    localparam int IDX_W      = 3;
    localparam int VAL_W      = FRAC_BITS + 6;
    localparam int MAG_W      = FRAC_BITS + 1;
    localparam int PROD_W     = FRAC_BITS + 2;
    localparam int PIX_W      = COORD_BITS + REG_W;
    localparam int SAT_W      = FRAC_BITS + 3;

    localparam logic [VAL_W-1:0]  TWO_V   = VAL_W'(1) << (FRAC_BITS + 1);
    localparam logic [PROD_W:0]   FOUR_P  = (PROD_W + 1)'(1) << (FRAC_BITS + 2);
    localparam logic [PIX_W-1:0]  PIX_SAT = PIX_W'(1) << (FRAC_BITS + 2);

    localparam logic [REG_W-1:0] C_REAL_RST = '0;
    localparam logic [REG_W-1:0] C_IMAG_RST = '0;
    localparam logic [REG_W-1:0] X_STEP_RST = REG_W'(1677722);
    localparam logic [REG_W-1:0] Y_STEP_RST = REG_W'(2236963);
    localparam logic [CNT_W-1:0] LIMIT_RST  = CNT_W'(64);

    typedef enum logic [IDX_W-1:0] {
        REG_C_REAL = 3'd0,
        REG_C_IMAG = 3'd1,
        REG_X_STEP = 3'd2,
        REG_Y_STEP = 3'd3,
        REG_LIMIT  = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        CH_RED   = 2'd0,
        CH_GREEN = 2'd1,
        CH_BLUE  = 2'd2
    } channel_t;

    typedef struct packed {
        logic [REG_W-1:0] c_real;
        logic [REG_W-1:0] c_imag;
        logic [REG_W-1:0] x_step;
        logic [REG_W-1:0] y_step;
        logic [CNT_W-1:0] limit;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] red;
        logic [CNT_W-1:0] green;
        logic [CNT_W-1:0] blue;
    } counts_t;

    typedef struct packed {
        logic    idle;
        logic    done;
        counts_t counts;
    } core_status_t;

endpackage

@@ rtl/core/jet_cfg_regs.sv @@
module jet_cfg_regs
    import jet_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_C_REAL: cfg_next.c_real = cfg_data;
                REG_C_IMAG: cfg_next.c_imag = cfg_data;
                REG_X_STEP: cfg_next.x_step = cfg_data;
                REG_Y_STEP: cfg_next.y_step = cfg_data;
                REG_LIMIT:  cfg_next.limit  = cfg_data[CNT_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.c_real <= C_REAL_RST;
            cfg_reg.c_imag <= C_IMAG_RST;
            cfg_reg.x_step <= X_STEP_RST;
            cfg_reg.y_step <= Y_STEP_RST;
            cfg_reg.limit  <= LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/jet_mult.sv @@
module jet_mult
    import jet_pkg::*;
(
    input  logic              clk,
    input  logic [MAG_W-1:0]  a,
    input  logic [MAG_W-1:0]  b,
    output logic [PROD_W-1:0] p
);

    logic [2*MAG_W-1:0] full;
    logic [PROD_W-1:0]  p_reg;

    assign full = {{MAG_W{1'b0}}, a} * {{MAG_W{1'b0}}, b};

    // truncate toward zero: drop the fraction bits of the magnitude
    always_ff @(posedge clk)
    begin
        p_reg <= full[FRAC_BITS +: PROD_W];
    end

    assign p = p_reg;

endmodule

@@ rtl/core/jet_core.sv @@
module jet_core
    import jet_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    take,
    input  logic signed [VAL_W-1:0] x0,
    input  logic signed [VAL_W-1:0] y0,
    input  cfg_t                    cfg,
    output core_status_t            status
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_SQY   = 6'b000100,
        ST_XY    = 6'b001000,
        ST_UPD   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    channel_t                ch_reg, ch_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [VAL_W-1:0] x_reg, x_next;
    logic signed [VAL_W-1:0] y_reg, y_next;
    logic signed [VAL_W-1:0] x0_reg, x0_next;
    logic signed [VAL_W-1:0] y0_reg, y0_next;
    logic [PROD_W-1:0]       px_reg, px_next;
    logic [PROD_W-1:0]       py_reg, py_next;
    counts_t                 counts_reg, counts_next;

    logic [VAL_W-1:0]        mx_full, my_full;
    logic [MAG_W-1:0]        mx, my;
    logic                    escaped;
    logic [MAG_W-1:0]        op_a, op_b;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W:0]         mag_sum;
    logic signed [VAL_W-1:0] cre, cim;
    logic signed [VAL_W-1:0] nx, ny, two_xy;
    logic [CNT_W-1:0]        count_inc;
    logic                    finish;
    logic [CNT_W-1:0]        finish_count;

    assign mx_full = x_reg[VAL_W-1] ? VAL_W'(-x_reg) : VAL_W'(x_reg);
    assign my_full = y_reg[VAL_W-1] ? VAL_W'(-y_reg) : VAL_W'(y_reg);
    assign mx      = mx_full[MAG_W-1:0];
    assign my      = my_full[MAG_W-1:0];
    assign escaped = (mx_full >= TWO_V) || (my_full >= TWO_V);

    always_comb
    begin
        op_a = mx;
        op_b = mx;
        unique case (state_reg)
            ST_SQY:
            begin
                op_a = my;
                op_b = my;
            end
            ST_XY:
            begin
                op_a = mx;
                op_b = my;
            end
            default:
            begin
                op_a = mx;
                op_b = mx;
            end
        endcase
    end

    jet_mult u_mult (
        .clk (clk),
        .a   (op_a),
        .b   (op_b),
        .p   (prod)
    );

    always_comb
    begin
        case (ch_reg)
            CH_RED:
            begin
                cre = VAL_W'($signed(cfg.c_real));
                cim = VAL_W'($signed(cfg.c_real));
            end
            CH_GREEN:
            begin
                cre = VAL_W'($signed(cfg.c_real));
                cim = VAL_W'($signed(cfg.c_imag));
            end
            default:
            begin
                cre = VAL_W'($signed(cfg.c_imag));
                cim = VAL_W'($signed(cfg.c_imag));
            end
        endcase
    end

    assign mag_sum   = {1'b0, px_reg} + {1'b0, py_reg};
    assign two_xy    = $signed({{(VAL_W-PROD_W-1){1'b0}}, prod, 1'b0});
    assign nx        = $signed({{(VAL_W-PROD_W){1'b0}}, px_reg})
                     - $signed({{(VAL_W-PROD_W){1'b0}}, py_reg}) + cre;
    assign ny        = ((x_reg[VAL_W-1] ^ y_reg[VAL_W-1]) ? -two_xy : two_xy) + cim;
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        count_next   = count_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        x0_next      = x0_reg;
        y0_next      = y0_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        counts_next  = counts_reg;
        finish       = 1'b0;
        finish_count = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    x0_next    = x0;
                    y0_next    = y0;
                    x_next     = x0;
                    y_next     = y0;
                    ch_next    = CH_RED;
                    count_next = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (escaped)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    state_next = ST_SQY;
                end
            end
            ST_SQY:
            begin
                px_next    = prod;
                state_next = ST_XY;
            end
            ST_XY:
            begin
                py_next    = prod;
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (mag_sum >= FOUR_P)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    x_next     = nx;
                    y_next     = ny;
                    count_next = count_inc;
                    if (count_inc >= cfg.limit)
                    begin
                        finish       = 1'b1;
                        finish_count = count_inc;
                    end
                    else
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // store this channel's count, then restart from the pixel's start point
        if (finish)
        begin
            x_next     = x0_reg;
            y_next     = y0_reg;
            count_next = '0;
            state_next = ST_CHECK;
            case (ch_reg)
                CH_RED:
                begin
                    counts_next.red = finish_count;
                    ch_next         = CH_GREEN;
                end
                CH_GREEN:
                begin
                    counts_next.green = finish_count;
                    ch_next           = CH_BLUE;
                end
                default:
                begin
                    counts_next.blue = finish_count;
                    state_next       = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_RED;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        counts_reg <= counts_next;
    end

    assign status.idle   = (state_reg == ST_IDLE);
    assign status.done   = (state_reg == ST_DONE);
    assign status.counts = counts_reg;

endmodule

@@ rtl/core/julia_escape_time_rgb.sv @@
// Julia escape-time counter, three channels per pixel. Each item is one pixel
// position, mapped to z0 = (pixel_x*x_step - 2.0, pixel_y*y_step - 2.0) in
// signed Q6.28, and iterated z = z^2 + c once per channel with c = (re,re),
// (re,im) and (im,im); each count stops at the escape |z|^2 >= 4.0 or at the
// iteration limit. One multiplier is shared by all work: every iteration
// steps through CHECK, SQY, XY and UPD (x^2, y^2, x*y, update). A channel
// runs at most limit iterations, or one at a limit of 0, and a start point
// already at or past 2.0 ends its channel in CHECK with a count of zero.
// An accepted item runs its three channels in turn and is then handed to
// the output register. The input is stalled while an item is in work; a
// finished result waits in the output register, so the next item can start
// before it is taken. Running maxima of the three counts are cleared by
// frame_start before that pixel is counted.
// Write the registers only while the block is idle.
module julia_escape_time_rgb
    import jet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [REG_W-1:0]      cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_BITS-1:0] pixel_x,
    input  logic [COORD_BITS-1:0] pixel_y,
    input  logic                  frame_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CNT_W-1:0]      red_count,
    output logic [CNT_W-1:0]      green_count,
    output logic [CNT_W-1:0]      blue_count,
    output logic [CNT_W-1:0]      red_max,
    output logic [CNT_W-1:0]      green_max,
    output logic [CNT_W-1:0]      blue_max
);

    cfg_t                    cfg;
    core_status_t            status;
    logic                    start;
    logic                    take;
    logic                    emit;
    logic [PIX_W-1:0]        x_prod, y_prod;
    logic [SAT_W-1:0]        x_sat, y_sat;
    logic signed [VAL_W-1:0] x0, y0;

    logic                    out_valid_reg, out_valid_next;
    logic                    fs_reg, fs_next;
    counts_t                 max_reg, max_next;
    counts_t                 base;
    counts_t                 cnt_out_reg;
    counts_t                 max_out_reg;

    jet_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // clamp far-off coordinates: anything past +2.0 escapes the same way
    assign x_prod = PIX_W'(pixel_x) * PIX_W'(cfg.x_step);
    assign y_prod = PIX_W'(pixel_y) * PIX_W'(cfg.y_step);
    assign x_sat  = (x_prod >= PIX_SAT) ? PIX_SAT[SAT_W-1:0] : x_prod[SAT_W-1:0];
    assign y_sat  = (y_prod >= PIX_SAT) ? PIX_SAT[SAT_W-1:0] : y_prod[SAT_W-1:0];
    assign x0     = $signed({{(VAL_W-SAT_W){1'b0}}, x_sat}) - $signed(TWO_V);
    assign y0     = $signed({{(VAL_W-SAT_W){1'b0}}, y_sat}) - $signed(TWO_V);

    assign in_stall = !status.idle;
    assign start    = in_valid && status.idle;
    assign take     = !out_valid_reg || !out_stall;
    assign emit     = status.done && take;

    jet_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .take   (take),
        .x0     (x0),
        .y0     (y0),
        .cfg    (cfg),
        .status (status)
    );

    always_comb
    begin
        base     = fs_reg ? '0 : max_reg;
        max_next = max_reg;
        fs_next  = start ? frame_start : fs_reg;
        if (emit)
        begin
            max_next.red   = (status.counts.red > base.red) ? status.counts.red : base.red;
            max_next.green = (status.counts.green > base.green) ?
                             status.counts.green : base.green;
            max_next.blue  = (status.counts.blue > base.blue) ?
                             status.counts.blue : base.blue;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            max_reg       <= '0;
            fs_reg        <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            max_reg       <= max_next;
            fs_reg        <= fs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cnt_out_reg <= status.counts;
            max_out_reg <= max_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_count   = cnt_out_reg.red;
    assign green_count = cnt_out_reg.green;
    assign blue_count  = cnt_out_reg.blue;
    assign red_max     = max_out_reg.red;
    assign green_max   = max_out_reg.green;
    assign blue_max    = max_out_reg.blue;

endmodule

@@ verif/tb_top.sv @@
module tb_top;
    import jet_pkg::*;

    typedef struct packed {
        counts_t cnt;
        counts_t peak;
    } pixel_result_t;

    typedef struct {
        bit                    is_cfg;
        cfg_index_t            idx;
        logic [REG_W-1:0]      data;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  fs;
        bit                    typed;
        pixel_result_t         want;
    } dir_row_t;

    localparam longint unsigned TWO_Q  = 64'd1 << (FRAC_BITS + 1);
    localparam longint unsigned FOUR_Q = 64'd1 << (FRAC_BITS + 2);
    localparam longint          TWO_S  = 64'sd1 <<< (FRAC_BITS + 1);

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [IDX_W-1:0]      cfg_index;
    logic [REG_W-1:0]      cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_stall;
    logic [CNT_W-1:0]      red_count;
    logic [CNT_W-1:0]      green_count;
    logic [CNT_W-1:0]      blue_count;
    logic [CNT_W-1:0]      red_max;
    logic [CNT_W-1:0]      green_max;
    logic [CNT_W-1:0]      blue_max;

    cfg_t             shadow_cfg;
    logic [CNT_W-1:0] frame_peak [3];
    pixel_result_t    pending_results [$];
    dir_row_t         dir_rows [$];
    int               errors;
    bit               quiet;
    bit               hold_req;

    julia_escape_time_rgb uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_count   (red_count),
        .green_count (green_count),
        .blue_count  (blue_count),
        .red_max     (red_max),
        .green_max   (green_max),
        .blue_max    (blue_max)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic longint unsigned frac_mul(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[FRAC_BITS +: 64];
    endfunction

    function automatic int unsigned escape_iters(longint x, longint y, longint cre,
                                                 longint cim, int unsigned limit);
        longint unsigned mx;
        longint unsigned my;
        longint unsigned sx;
        longint unsigned sy;
        longint          xy;
        longint          nx;
        int unsigned     n;
        bit              run;
        n = 0;
        run = 1'b1;
        while (run)
        begin
            mx = (x < 0) ? -x : x;
            my = (y < 0) ? -y : y;
            if (mx >= TWO_Q || my >= TWO_Q)
                run = 1'b0;
            else
            begin
                sx = frac_mul(mx, mx);
                sy = frac_mul(my, my);
                if (sx + sy >= FOUR_Q)
                    run = 1'b0;
                else
                begin
                    xy = frac_mul(mx, my);
                    if ((x < 0) != (y < 0))
                        xy = -xy;
                    nx = longint'(sx) - longint'(sy) + cre;
                    y = 2 * xy + cim;
                    x = nx;
                    n++;
                    if (n >= limit)
                        run = 1'b0;
                end
            end
        end
        return n;
    endfunction

    function automatic pixel_result_t julia_pixel(logic [COORD_BITS-1:0] px,
                                                  logic [COORD_BITS-1:0] py, logic fs);
        longint        x0;
        longint        y0;
        longint        cre;
        longint        cim;
        int unsigned   n [3];
        pixel_result_t r;
        x0 = $signed({52'd0, px}) * $signed({33'd0, shadow_cfg.x_step}) - TWO_S;
        y0 = $signed({52'd0, py}) * $signed({33'd0, shadow_cfg.y_step}) - TWO_S;
        cre = longint'($signed(shadow_cfg.c_real));
        cim = longint'($signed(shadow_cfg.c_imag));
        if (fs)
        begin
            frame_peak[CH_RED] = '0;
            frame_peak[CH_GREEN] = '0;
            frame_peak[CH_BLUE] = '0;
        end
        n[CH_RED] = escape_iters(x0, y0, cre, cre, shadow_cfg.limit);
        n[CH_GREEN] = escape_iters(x0, y0, cre, cim, shadow_cfg.limit);
        n[CH_BLUE] = escape_iters(x0, y0, cim, cim, shadow_cfg.limit);
        for (int k = 0; k < 3; k++)
            if (n[k] > frame_peak[k])
                frame_peak[k] = CNT_W'(n[k]);
        r.cnt.red = CNT_W'(n[CH_RED]);
        r.cnt.green = CNT_W'(n[CH_GREEN]);
        r.cnt.blue = CNT_W'(n[CH_BLUE]);
        r.peak.red = frame_peak[CH_RED];
        r.peak.green = frame_peak[CH_GREEN];
        r.peak.blue = frame_peak[CH_BLUE];
        return r;
    endfunction

    function automatic dir_row_t item_row(int px, int py, bit fs, bit typed,
                                          int r, int g, int b, int rm, int gm, int bm);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.idx = REG_C_REAL;
        row.data = '0;
        row.px = COORD_BITS'(px);
        row.py = COORD_BITS'(py);
        row.fs = fs;
        row.typed = typed;
        row.want.cnt.red = CNT_W'(r);
        row.want.cnt.green = CNT_W'(g);
        row.want.cnt.blue = CNT_W'(b);
        row.want.peak.red = CNT_W'(rm);
        row.want.peak.green = CNT_W'(gm);
        row.want.peak.blue = CNT_W'(bm);
        return row;
    endfunction

    function automatic dir_row_t cfg_row(cfg_index_t idx, logic [REG_W-1:0] data);
        dir_row_t row;
        row = item_row(0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0);
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic void check_field(string name, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // hold the input low and wait until every pixel has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [REG_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_C_REAL: shadow_cfg.c_real = data;
            REG_C_IMAG: shadow_cfg.c_imag = data;
            REG_X_STEP: shadow_cfg.x_step = data;
            REG_Y_STEP: shadow_cfg.y_step = data;
            REG_LIMIT:  shadow_cfg.limit = data[CNT_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic offer_pixel(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                               logic fs, bit typed, pixel_result_t want);
        int            gap;
        pixel_result_t pred;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_x <= px;
        pixel_y <= py;
        frame_start <= fs;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        pred = julia_pixel(px, py, fs);
        pending_results.push_back(typed ? want : pred);
    endtask

    initial
    begin
        int                    wx;
        int                    wy;
        int                    lim;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  fs;
        dir_row_t              row;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_C_REAL;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        frame_start = 1'b0;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        shadow_cfg = {C_REAL_RST, C_IMAG_RST, X_STEP_RST, Y_STEP_RST, LIMIT_RST};
        frame_peak[CH_RED] = '0;
        frame_peak[CH_GREEN] = '0;
        frame_peak[CH_BLUE] = '0;

        dir_rows.push_back(item_row(0, 0, 1'b1, 1'b1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(item_row(320, 240, 1'b0, 1'b1, 64, 64, 64, 64, 64, 64));
        dir_rows.push_back(item_row(4095, 4095, 1'b0, 1'b1, 0, 0, 0, 64, 64, 64));
        dir_rows.push_back(item_row(0, 4095, 1'b0, 1'b1, 0, 0, 0, 64, 64, 64));
        dir_rows.push_back(item_row(4095, 0, 1'b1, 1'b1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(item_row(320, 240, 1'b0, 1'b1, 64, 64, 64, 64, 64, 64));
        dir_rows.push_back(cfg_row(REG_LIMIT, REG_W'(0)));
        dir_rows.push_back(item_row(320, 240, 1'b1, 1'b1, 1, 1, 1, 1, 1, 1));
        dir_rows.push_back(cfg_row(REG_LIMIT, REG_W'(127)));
        dir_rows.push_back(item_row(320, 240, 1'b0, 1'b1, 127, 127, 127, 127, 127, 127));
        dir_rows.push_back(cfg_row(REG_LIMIT, REG_W'(100)));
        dir_rows.push_back(cfg_row(REG_C_REAL, REG_W'(-536870912)));
        dir_rows.push_back(cfg_row(REG_C_IMAG, REG_W'(536870912)));
        dir_rows.push_back(item_row(320, 240, 1'b1, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(item_row(160, 120, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(item_row(480, 360, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_C_REAL, REG_W'(536870912)));
        dir_rows.push_back(cfg_row(REG_C_IMAG, REG_W'(-536870912)));
        dir_rows.push_back(item_row(320, 240, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_X_STEP, REG_W'(0)));
        dir_rows.push_back(cfg_row(REG_Y_STEP, REG_W'(1073741824)));
        dir_rows.push_back(item_row(4095, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(item_row(0, 1, 1'b1, 1'b0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(cfg_row(REG_X_STEP, REG_W'(1073741824)));
        dir_rows.push_back(cfg_row(REG_Y_STEP, REG_W'(0)));
        dir_rows.push_back(item_row(1, 4095, 1'b0, 1'b0, 0, 0, 0, 0, 0, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < dir_rows.size(); i++)
        begin
            row = dir_rows[i];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.idx, row.data);
            end
            else
                offer_pixel(row.px, row.py, row.fs, row.typed, row.want);
        end

        for (int p = 0; p < 10; p++)
        begin
            settle();
            quiet = 1'b0;
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_C_REAL, REG_W'(int'($urandom_range(0, 1073741824)) - 536870912));
            else
                write_reg(REG_C_REAL, REG_W'(int'($urandom_range(0, 402653184)) - 201326592));
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_C_IMAG, REG_W'(int'($urandom_range(0, 1073741824)) - 536870912));
            else
                write_reg(REG_C_IMAG, REG_W'(int'($urandom_range(0, 402653184)) - 201326592));
            wx = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64) : $urandom_range(65, 4096);
            wy = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 64) : $urandom_range(65, 4096);
            write_reg(REG_X_STEP, REG_W'(32'h4000_0000 / wx));
            write_reg(REG_Y_STEP, REG_W'(32'h4000_0000 / wy));
            case (p)
                0:       lim = 1;
                1:       lim = 0;
                3:       lim = 100;
                4:       lim = 10;
                5:       lim = 127;
                default: lim = $urandom_range(2, 40);
            endcase
            write_reg(REG_LIMIT, REG_W'(lim));
            quiet = (p == 2);
            if (p == 4)
                hold_req = 1'b1;
            for (int i = 0; i < 55; i++)
            begin
                if (p == 6 && i == 27)
                    settle();
                if ($urandom_range(0, 4) == 0)
                    px = COORD_BITS'($urandom());
                else
                    px = COORD_BITS'($urandom_range(0, wx - 1));
                if ($urandom_range(0, 4) == 0)
                    py = COORD_BITS'($urandom());
                else
                    py = COORD_BITS'($urandom_range(0, wy - 1));
                fs = (i == 0) || ($urandom_range(0, 15) == 0);
                offer_pixel(px, py, fs, 1'b0, '0);
            end
        end

        quiet = 1'b0;
        settle();
        repeat (1600) @(posedge clk);
        if (errors == 0)
            $display("julia_escape_time_rgb: match");
        else
            $display("julia_escape_time_rgb: mismatch");
        $finish;
    end

    initial
    begin
        int            n;
        pixel_result_t want;
        out_stall = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
            end
            n = quiet ? 0 : $urandom_range(0, 17);
            if (n != 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no pixel pending, got %0d %0d %0d", $time,
                         red_count, green_count, blue_count);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("red_count", want.cnt.red, red_count);
                check_field("green_count", want.cnt.green, green_count);
                check_field("blue_count", want.cnt.blue, blue_count);
                check_field("red_max", want.peak.red, red_max);
                check_field("green_max", want.peak.green, green_max);
                check_field("blue_max", want.peak.blue, blue_max);
            end
        end
    end

    initial
    begin
        #60000000;
        $display("julia_escape_time_rgb: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/jet_pkg.sv
rtl/core/jet_cfg_regs.sv
rtl/core/jet_mult.sv
rtl/core/jet_core.sv
rtl/core/julia_escape_time_rgb.sv
verif/tb_top.sv
